>>> rtl/core/fvn_pkg.sv
// Shared types, constants and the hash lookup table for the fractal value noise core.
`default_nettype none
package fvn_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 8;
    localparam int COORD_W   = INT_BITS + FRAC_BITS;
    localparam int OUT_W     = 16;
    localparam int PROD_SH   = 32 - FRAC_BITS;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_SEED = 2'd0;
    localparam logic [1:0] REG_FREQ = 2'd1;
    localparam logic [1:0] REG_OCT  = 2'd2;

    localparam logic [23:0] FREQ_RESET = 24'h010000;
    localparam logic [3:0]  OCT_RESET  = 4'd1;

    typedef logic [COORD_W-1:0] coord_word_t;

    typedef struct packed {
        coord_word_t x;
        coord_word_t y;
        coord_word_t z;
    } coord_t;

    localparam logic [7:0] PERM [256] = '{
        8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,  8'd161, 8'd78,
        8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
        8'd40,  8'd185, 8'd248, 8'd251, 8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,
        8'd36,  8'd1,   8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
        8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174, 8'd173, 8'd102,
        8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44,  8'd43,  8'd77,
        8'd180, 8'd204, 8'd8,   8'd81,  8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254,
        8'd210, 8'd210, 8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
        8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,   8'd47,  8'd104,
        8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
        8'd70,  8'd180, 8'd174, 8'd0,   8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116,
        8'd127, 8'd198, 8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
        8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
        8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195, 8'd38,  8'd58,  8'd65,  8'd207,
        8'd215, 8'd253, 8'd65,  8'd85,  8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,
        8'd89,  8'd232, 8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
        8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
        8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97,  8'd53,  8'd145, 8'd135,
        8'd19,  8'd103, 8'd13,  8'd90,  8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247,
        8'd33,  8'd39,  8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
        8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158, 8'd42,  8'd30,
        8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
        8'd115, 8'd184, 8'd21,  8'd233, 8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128,
        8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
        8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250, 8'd209, 8'd92,
        8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
    };

endpackage
`default_nettype wire

>>> rtl/core/fractal_value_noise_3d.sv
// Top level of the fractal value noise core: register port, input scaling, octave chain, divider.
//
// Usage: present a point on point_x/point_y/point_z (signed Q16.16) with start high; the word
// is taken at any rising edge where start is high and busy is low. busy never rises, so one
// point may enter every cycle. The result word appears on noise_value (unsigned Q0.16) with
// done high for exactly one cycle; the receiver cannot stall it, so sample it when done is high.
// The path is: one scaling multiply stage, a chain of MAX_OCTAVES octave cells of seven stages
// each (every cell is always traversed; cells past octave_count pass the sum unchanged),
// then the divider: one input stage and sixteen stages of one quotient bit each. The chain
// length sets the latency; throughput is one word per cycle.
// Registers on the APB port: seed_offset at 0x0, frequency at 0x4, octave_count at 0x8.
// Write them only while no word is in flight. octave_count 0 acts as 1, values above
// MAX_OCTAVES act as MAX_OCTAVES. Writes elsewhere are ignored; pready is always high.
// Reset clears the pipeline valid bits and loads seed 0, frequency 1.0, one octave.
`default_nettype none
module fractal_value_noise_3d #(
    parameter int MAX_OCTAVES = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [31:0]            point_x,
    input  wire logic signed [31:0]            point_y,
    input  wire logic signed [31:0]            point_z,
    output logic                               done,
    output logic [15:0]                        noise_value,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fvn_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fvn_pkg::DATA_W-1:0]    pwdata,
    output logic [fvn_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    localparam int CW    = fvn_pkg::COORD_W;
    localparam int SH    = fvn_pkg::PROD_SH;
    localparam int ACC_W = CW + MAX_OCTAVES;
    localparam int NW    = $clog2(MAX_OCTAVES + 1);

    // configuration registers
    logic [7:0]  seed_reg;
    logic [23:0] freq_reg;
    logic [3:0]  oct_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            freq_reg <= fvn_pkg::FREQ_RESET;
            oct_reg  <= fvn_pkg::OCT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                fvn_pkg::REG_SEED: seed_reg <= pwdata[7:0];
                fvn_pkg::REG_FREQ: freq_reg <= pwdata[23:0];
                fvn_pkg::REG_OCT:  oct_reg  <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fvn_pkg::REG_SEED: prdata = {24'b0, seed_reg};
            fvn_pkg::REG_FREQ: prdata = {8'b0, freq_reg};
            fvn_pkg::REG_OCT:  prdata = {28'b0, oct_reg};
            default:           prdata = '0;
        endcase
    end

    // effective octave count and divisor 2^n - 1
    logic [NW-1:0]          n_eff;
    logic [MAX_OCTAVES:0]   div_wide;
    logic [MAX_OCTAVES-1:0] divisor;

    always_comb
    begin
        if (oct_reg == 4'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(oct_reg) > MAX_OCTAVES)
        begin
            n_eff = NW'(MAX_OCTAVES);
        end
        else
        begin
            n_eff = NW'(oct_reg);
        end
        div_wide = ((MAX_OCTAVES+1)'(1) << n_eff) - (MAX_OCTAVES+1)'(1);
        divisor  = div_wide[MAX_OCTAVES-1:0];
    end

    // scale stage: keep the low 8 integer bits and the fraction of point * frequency
    logic signed [56:0] prod_x, prod_y, prod_z;
    logic               scl_vld_reg;
    fvn_pkg::coord_t    scl_reg;

    assign prod_x = point_x * $signed({1'b0, freq_reg});
    assign prod_y = point_y * $signed({1'b0, freq_reg});
    assign prod_z = point_z * $signed({1'b0, freq_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_vld_reg <= 1'b0;
        end
        else
        begin
            scl_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        scl_reg.x <= prod_x[SH+CW-1:SH];
        scl_reg.y <= prod_y[SH+CW-1:SH];
        scl_reg.z <= prod_z[SH+CW-1:SH];
    end

    // octave chain
    logic            lnk_vld [MAX_OCTAVES+1];
    fvn_pkg::coord_t lnk_crd [MAX_OCTAVES+1];
    logic [ACC_W-1:0] lnk_acc [MAX_OCTAVES+1];

    assign lnk_vld[0] = scl_vld_reg;
    assign lnk_crd[0] = scl_reg;
    assign lnk_acc[0] = '0;

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_oct
        logic act;
        assign act = 32'(n_eff) > i;

        fvn_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (act),
            .seed      (seed_reg),
            .in_valid  (lnk_vld[i]),
            .in_coord  (lnk_crd[i]),
            .in_acc    (lnk_acc[i]),
            .out_valid (lnk_vld[i+1]),
            .out_coord (lnk_crd[i+1]),
            .out_acc   (lnk_acc[i+1])
        );
    end

    // normalize: sum / (256 * (2^n - 1)), landing in Q0.16
    fvn_div #(
        .DW    (MAX_OCTAVES),
        .ACC_W (ACC_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lnk_vld[MAX_OCTAVES]),
        .in_acc    (lnk_acc[MAX_OCTAVES]),
        .divisor   (divisor),
        .out_valid (done),
        .quotient  (noise_value)
    );

endmodule
`default_nettype wire

>>> rtl/core/fvn_cell.sv
// One octave cell: hashes the 8 lattice corners, blends them and folds the octave into the sum.
`default_nettype none
module fvn_cell #(
    parameter int ACC_W = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               active,
    input  wire logic [7:0]         seed,
    input  wire logic               in_valid,
    input  wire fvn_pkg::coord_t    in_coord,
    input  wire logic [ACC_W-1:0]   in_acc,
    output logic                    out_valid,
    output fvn_pkg::coord_t         out_coord,
    output logic [ACC_W-1:0]        out_acc
);
    localparam int FB  = fvn_pkg::FRAC_BITS;
    localparam int IB  = fvn_pkg::INT_BITS;
    localparam int CW  = fvn_pkg::COORD_W;
    localparam int LAT = 7;
    localparam int EW  = IB + FB + 2;
    localparam int BW  = CW + FB + 2;
    localparam logic [FB:0]   ONE   = {1'b1, {FB{1'b0}}};
    localparam logic [FB+1:0] THREE = {2'b11, {FB{1'b0}}};

    // stage 0: first hash level, ease square and slope
    logic [CW-1:0] pt [3];
    logic [7:0]    a_next [2];
    logic [FB-1:0] sq_next [3];
    logic [FB+1:0] w_next [3];
    logic [2*FB-1:0] sq_prod [3];

    logic [7:0]    a_reg [2];
    logic [7:0]    xi1_reg, zi1_reg;
    logic [FB-1:0] sq_reg [3];
    logic [FB+1:0] w_reg [3];

    // stage 1
    logic [2*FB+1:0] t_prod [3];
    logic [FB:0]     t_next [3];
    logic [7:0]      b_next [4];
    logic [7:0]      b_reg [4];
    logic [7:0]      xi2_reg;
    logic [FB:0]     t2_reg [3];

    // stage 2
    logic [7:0]  c_next [8];
    logic [7:0]  c_reg [8];
    logic [FB:0] t3_reg [3];

    // stage 3
    logic [EW-1:0] e_wide [4];
    logic [CW-1:0] e_reg [4];
    logic [FB:0]   ty4_reg, tz4_reg;

    // stage 4
    logic [BW-1:0] f_wide [2];
    logic [CW-1:0] f_reg [2];
    logic [FB:0]   tz5_reg;

    // stage 5
    logic [BW-1:0] n_wide;
    logic [CW-1:0] n_reg;

    // side lines
    logic [LAT-1:0]   vld_reg;
    fvn_pkg::coord_t  crd_reg [LAT];
    logic [ACC_W-1:0] acc_reg [LAT-1];
    logic [ACC_W-1:0] acc_out_reg;
    logic [ACC_W-1:0] acc_out_next;

    assign pt[0] = in_coord.x;
    assign pt[1] = in_coord.y;
    assign pt[2] = in_coord.z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq_prod[k] = {{FB{1'b0}}, pt[k][FB-1:0]} * {{FB{1'b0}}, pt[k][FB-1:0]};
            sq_next[k] = sq_prod[k][2*FB-1:FB];
            w_next[k]  = THREE - {1'b0, pt[k][FB-1:0], 1'b0};
        end
        a_next[0] = fvn_pkg::PERM[8'(pt[1][CW-1:FB] + seed)];
        a_next[1] = fvn_pkg::PERM[8'(pt[1][CW-1:FB] + seed + 8'd1)];
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_prod[k] = (2*FB+2)'(sq_reg[k]) * (2*FB+2)'(w_reg[k]);
            t_next[k] = t_prod[k][2*FB:FB];
        end
        for (int y = 0; y < 2; y++)
        begin
            for (int z = 0; z < 2; z++)
            begin
                b_next[y*2+z] = fvn_pkg::PERM[8'(a_reg[y] + zi1_reg + 8'(z))];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            for (int x = 0; x < 2; x++)
            begin
                c_next[j*2+x] = fvn_pkg::PERM[8'(b_reg[j] + xi2_reg + 8'(x))];
            end
        end
    end

    // blend along x, then y, then z
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            e_wide[j] = EW'(c_reg[j*2]) * EW'(ONE - t3_reg[0])
                      + EW'(c_reg[j*2+1]) * EW'(t3_reg[0]);
        end
        for (int z = 0; z < 2; z++)
        begin
            f_wide[z] = BW'(e_reg[z]) * BW'(ONE - ty4_reg)
                      + BW'(e_reg[2+z]) * BW'(ty4_reg);
        end
        n_wide = BW'(f_reg[0]) * BW'(ONE - tz5_reg) + BW'(f_reg[1]) * BW'(tz5_reg);
        acc_out_next = active ? ((acc_reg[LAT-2] << 1) + ACC_W'(n_reg)) : acc_reg[LAT-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        xi1_reg <= pt[0][CW-1:FB];
        zi1_reg <= pt[2][CW-1:FB];
        sq_reg  <= sq_next;
        w_reg   <= w_next;

        b_reg   <= b_next;
        xi2_reg <= xi1_reg;
        t2_reg  <= t_next;

        c_reg   <= c_next;
        t3_reg  <= t2_reg;

        for (int j = 0; j < 4; j++)
        begin
            e_reg[j] <= e_wide[j][CW-1:0];
        end
        ty4_reg <= t3_reg[1];
        tz4_reg <= t3_reg[2];

        for (int z = 0; z < 2; z++)
        begin
            f_reg[z] <= f_wide[z][CW+FB-1:FB];
        end
        tz5_reg <= tz4_reg;

        n_reg <= n_wide[CW+FB-1:FB];

        crd_reg[0] <= in_coord;
        acc_reg[0] <= in_acc;
        for (int s = 1; s < LAT; s++)
        begin
            crd_reg[s] <= crd_reg[s-1];
        end
        for (int s = 1; s < LAT-1; s++)
        begin
            acc_reg[s] <= acc_reg[s-1];
        end
        acc_out_reg <= acc_out_next;
    end

    // double the coordinates for the next octave, wrapping in the same width
    assign out_valid   = vld_reg[LAT-1];
    assign out_coord.x = {crd_reg[LAT-1].x[CW-2:0], 1'b0};
    assign out_coord.y = {crd_reg[LAT-1].y[CW-2:0], 1'b0};
    assign out_coord.z = {crd_reg[LAT-1].z[CW-2:0], 1'b0};
    assign out_acc     = acc_out_reg;

endmodule
`default_nettype wire

>>> rtl/core/fvn_div.sv
// Pipelined restoring divider: normalizes the octave sum by 256 times the weight total.
`default_nettype none
module fvn_div #(
    parameter int DW    = 8,
    parameter int ACC_W = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [ACC_W-1:0]          in_acc,
    input  wire logic [DW-1:0]             divisor,
    output logic                           out_valid,
    output logic [fvn_pkg::OUT_W-1:0]      quotient
);
    localparam int QB = fvn_pkg::OUT_W;

    logic [QB:0]    vld_reg;
    logic [DW-1:0]  rem_reg [QB+1];
    logic [QB-1:0]  bits_reg [QB+1];
    logic [DW:0]    trial [QB];
    logic           ge [QB];
    logic [DW:0]    diff [QB];

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            trial[k] = {rem_reg[k], bits_reg[k][QB-1]};
            ge[k]    = trial[k] >= {1'b0, divisor};
            diff[k]  = trial[k] - {1'b0, divisor};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    // drop the low 8 bits of the sum, then one quotient bit per stage
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= in_acc[ACC_W-1:QB+8];
        bits_reg[0] <= in_acc[QB+7:8];
        for (int k = 0; k < QB; k++)
        begin
            rem_reg[k+1]  <= ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
            bits_reg[k+1] <= {bits_reg[k][QB-2:0], ge[k]};
        end
    end

    assign out_valid = vld_reg[QB];
    assign quotient  = bits_reg[QB];

endmodule
`default_nettype wire

>>> rtl/core/fvn_checker.sv
// Port-level checker for the fractal value noise core and its bind to the top level.
`default_nettype none
module fvn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [15:0] noise_value,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] prdata,
    input wire logic        pready
);
    // the core takes a word every cycle
    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // the normalized value never exceeds 255/256
    a_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (noise_value <= 16'hFF00))
        else $error("noise_value out of range");

    // with no write, a read of the same register holds its value
    a_read_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && pready && !(psel && penable && pwrite)) ##1
        (psel && !pwrite && $stable(paddr) && !$past(psel && penable && pwrite))
        |-> $stable(prdata))
        else $error("register read changed without a write");

endmodule

bind fractal_value_noise_3d fvn_checker u_fvn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .done        (done),
    .noise_value (noise_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .prdata      (prdata),
    .pready      (pready)
);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the fractal value noise core: directed and random points.
module tb;

    localparam int MAX_OCT  = 8;
    localparam int LATENCY  = 7 * MAX_OCT + 18;
    localparam logic [3:0] ADDR_SEED = 4'h0;
    localparam logic [3:0] ADDR_FREQ = 4'h4;
    localparam logic [3:0] ADDR_OCT  = 4'h8;
    localparam logic [3:0] ADDR_VOID = 4'hC;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
    logic done;
    logic [15:0] noise_value;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [fvn_pkg::ADDR_W-1:0] paddr = '0;
    logic [fvn_pkg::DATA_W-1:0] pwdata = '0;
    logic [fvn_pkg::DATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the register file, used by the noise predictor.
    logic [7:0]  seed_q = 8'd0;
    logic [23:0] freq_q = fvn_pkg::FREQ_RESET;
    logic [3:0]  oct_q  = fvn_pkg::OCT_RESET;

    logic [15:0] noise_pending[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    bit          idle_on = 1'b1;

    always #5 clk = ~clk;

    fractal_value_noise_3d #(.MAX_OCTAVES(MAX_OCT)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .done(done), .noise_value(noise_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ---------------- predictor ----------------
    function automatic logic [23:0] scale_coord(logic signed [31:0] raw);
        logic signed [63:0] prod;
        prod = 64'(raw) * $signed({40'd0, freq_q});
        // floor to 16 fraction bits, keep 8 integer bits
        return prod[39:16];
    endfunction

    function automatic logic [16:0] smooth_weight(logic [15:0] s);
        logic [63:0] sq;
        logic [63:0] w;
        sq = (64'(s) * 64'(s)) >> 16;
        w  = 64'd196608 - 2 * 64'(s);
        return 17'((sq * w) >> 16);
    endfunction

    function automatic logic [63:0] lerp_fx(logic [63:0] a, logic [63:0] b, logic [63:0] t);
        return (a * (64'd65536 - t) + b * t) >> 16;
    endfunction

    function automatic logic [63:0] lattice_value(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz);
        logic [7:0] a;
        logic [7:0] b;
        a = fvn_pkg::PERM[8'(cy + seed_q)];
        b = fvn_pkg::PERM[8'(a + cz)];
        return 64'(fvn_pkg::PERM[8'(b + cx)]) << 16;
    endfunction

    function automatic logic [63:0] octave_value(logic [23:0] px, logic [23:0] py,
                                                 logic [23:0] pz);
        logic [7:0]  xi, yi, zi, zk;
        logic [63:0] tx, ty, tz, lo, hi;
        logic [63:0] layer[2];
        xi = px[23:16]; yi = py[23:16]; zi = pz[23:16];
        tx = 64'(smooth_weight(px[15:0]));
        ty = 64'(smooth_weight(py[15:0]));
        tz = 64'(smooth_weight(pz[15:0]));
        for (int k = 0; k < 2; k++)
        begin
            zk = 8'(zi + k);
            lo = lerp_fx(lattice_value(xi, yi, zk), lattice_value(8'(xi + 1), yi, zk), tx);
            hi = lerp_fx(lattice_value(xi, 8'(yi + 1), zk),
                         lattice_value(8'(xi + 1), 8'(yi + 1), zk), tx);
            layer[k] = lerp_fx(lo, hi, ty);
        end
        return lerp_fx(layer[0], layer[1], tz);
    endfunction

    function automatic logic [15:0] fractal_noise(logic signed [31:0] x, logic signed [31:0] y,
                                                  logic signed [31:0] z);
        logic [23:0] px, py, pz;
        int          n;
        logic [63:0] acc;
        logic [63:0] div;
        px = scale_coord(x); py = scale_coord(y); pz = scale_coord(z);
        n = (oct_q == 0) ? 1 : (oct_q > MAX_OCT) ? MAX_OCT : int'(oct_q);
        acc = 0;
        for (int i = 0; i < n; i++)
        begin
            acc += octave_value(px, py, pz) << (n - 1 - i);
            px = px << 1; py = py << 1; pz = pz << 1;
        end
        div = ((64'd1 << n) - 1) << 24;
        return 16'((acc << 16) / div);
    endfunction

    // ---------------- drivers ----------------
    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic idle_burst();
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 13)) @(negedge clk);
    endtask

    // Send one word: hold start until accepted; predict it at the accepting edge.
    // Drop start at once so a following send in the same step can raise it again.
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        start   <= 1'b1;
        point_x <= x; point_y <= y; point_z <= z;
        do @(posedge clk); while (busy);
        noise_pending.push_back(fractal_noise(x, y, z));
        words_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // Hold off until the pipeline has drained, then allow the full latency.
    task automatic drain();
        while (noise_pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (addr)
            ADDR_SEED: seed_q = data[7:0];
            ADDR_FREQ: freq_q = data[23:0];
            ADDR_OCT:  oct_q  = data[3:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_config(logic [7:0] seed, logic [23:0] freq, logic [3:0] oct);
        drain();
        write_reg(ADDR_SEED, {24'd0, seed});
        write_reg(ADDR_FREQ, {8'd0, freq});
        write_reg(ADDR_OCT, {28'd0, oct});
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h000F_FFFF);
            3: return -$urandom_range(0, 32'h000F_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (noise_pending.size() == 0)
                report_mismatch("unexpected word", noise_value, 16'h0);
            else
            begin
                logic [15:0] want;
                want = noise_pending.pop_front();
                if (noise_value !== want)
                    report_mismatch("noise_value", noise_value, want);
                words_checked++;
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        // field extremes at reset configuration
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_0000);
        send_point(32'h00FF_FFFF, 32'hFF00_0001, 32'h0001_0000);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
        // zero octaves acts as one, too many saturates
        set_config(8'd0, 24'h010000, 4'd0);
        send_point(32'h0003_4000, 32'hFFFE_C000, 32'h0010_8000);
        set_config(8'd255, 24'hFFFFFF, 4'd15);
        send_point(32'h0003_4000, 32'hFFFE_C000, 32'h0010_8000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        set_config(8'd17, 24'h0, 4'd8);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        // out-of-range register write must be ignored
        drain();
        write_reg(ADDR_VOID, 32'hFFFF_FFFF);
        set_config(8'd3, 24'h000001, 4'd9);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            set_config(8'($urandom), ($urandom_range(0, 2) == 0) ? 24'($urandom)
                       : 24'($urandom_range(24'h004000, 24'h040000)),
                       4'($urandom_range(0, 15)));
            for (int i = 0; i < per_phase; i++)
            begin
                idle_burst();
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            // pause until every outstanding word has come back
            if (p == 2) drain();
        end
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        set_config(8'd255, 24'hFFFFFF, 4'd8);
        for (int i = 0; i < 100; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        set_config(8'd0, 24'h010000, 4'd1);
        for (int i = 0; i < 50; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(10, 100);
        test_streaming();
        drain();
        $display("Sent %0d points, checked %0d words over random seed,", words_sent,
                 words_checked);
        $display("frequency and octave settings, octave saturation and back-to-back streaming.");
        if (mismatches == 0 && noise_pending.size() == 0)
            $display("fractal_value_noise_3d verification clean");
        else
            $display("fractal_value_noise_3d verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("fractal_value_noise_3d verification failed");
        $finish;
    end
endmodule
